### design/plh_pkg.sv
// Shared types and constants for the pit/land run-length histogram.
package plh_pkg;

	// Command codes on the input channel.
	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Scale mode codes; the unused code behaves as no scaling.
	localparam logic [1:0] SCALE_NONE = 2'd0;
	localparam logic [1:0] SCALE_121  = 2'd1;
	localparam logic [1:0] SCALE_1452 = 2'd2;

	// Q16 scale factors, all 17 bits wide.
	localparam logic [16:0] Q16_ONE    = 17'd65536;
	localparam logic [16:0] Q16_X1_21  = 17'd79299;
	localparam logic [16:0] Q16_X1_452 = 17'd95158;

	// Sample layout: pit flag on top, raw length below it.
	localparam int PIT_BIT = 15;
	localparam int LEN_W   = 15;

	localparam int          COUNT_W   = 32;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// Work kinds that travel through the queue.
	typedef enum logic [1:0] {
		KIND_ADD,
		KIND_CLEAR,
		KIND_READ
	} plh_kind_t;

	// Classified request header.
	typedef struct packed {
		plh_kind_t kind;
		logic      table_sel;
		logic      oob;
	} plh_hdr_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		BK_INIT,
		BK_RUN,
		BK_CLEAR
	} plh_back_state_t;

endpackage

### design/pit_land_length_histogram.sv
// Top level of the pit/land run-length histogram.
// Throughput: one add or read request per cycle when nothing stalls, set by the single read port of each table RAM.
// A read request passes through the capture register, the queue, the RAM read register and the result register.
// A clear waits for the pipeline to drain, then writes zeros to every bin of both tables.
// After reset both tables are swept to zero while in_stall stays high.
// The configuration register is taken in the cycle its write arrives.
module pit_land_length_histogram import plh_pkg::*; #(
	parameter int BINS = 512
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   scale_mode,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   command,
	input  logic [15:0]  sample,
	input  logic [8:0]   bin_index,
	input  logic         table_select,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [31:0]  bin_count
);

	localparam int ADDR_W = $clog2(BINS);

	logic              push_valid;
	plh_hdr_t          push_hdr;
	logic [ADDR_W-1:0] push_addr;
	logic              q_full;
	logic              pop;
	logic              head_valid;
	plh_hdr_t          head_hdr;
	logic [ADDR_W-1:0] head_addr;
	logic              init_busy;

	plh_front #(
		.BINS (BINS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.scale_mode   (scale_mode),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.sample       (sample),
		.bin_index    (bin_index),
		.table_select (table_select),
		.hold         (init_busy),
		.q_full       (q_full),
		.push_valid   (push_valid),
		.push_hdr     (push_hdr),
		.push_addr    (push_addr)
	);

	plh_queue #(
		.ADDR_W (ADDR_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_hdr   (push_hdr),
		.push_addr  (push_addr),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_hdr   (head_hdr),
		.head_addr  (head_addr)
	);

	plh_back #(
		.BINS (BINS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_hdr   (head_hdr),
		.head_addr  (head_addr),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.bin_count  (bin_count),
		.init_busy  (init_busy)
	);

	// The front never pushes into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_valid && q_full))
		else $error("request pushed into full queue");

	// The back only pops a queue that holds a request.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	// The start-up clearing pass runs once and does not come back.
	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		!init_busy |=> !init_busy)
		else $error("initial clearing pass restarted");

	// No request leaves the queue while the tables are being swept at start-up.
	a_no_push_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !pop)
		else $error("request issued during initial clearing pass");

endmodule

### design/plh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port; a read at the written address sees old data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/plh_front.sv
// Front end: configuration register, request capture, scaling and bin selection.
module plh_front import plh_pkg::*; #(
	parameter int BINS = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               scale_mode,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               command,
	input  logic [15:0]              sample,
	input  logic [8:0]               bin_index,
	input  logic                     table_select,
	input  logic                     hold,
	input  logic                     q_full,
	output logic                     push_valid,
	output plh_hdr_t                 push_hdr,
	output logic [$clog2(BINS)-1:0]  push_addr
);

	localparam int ADDR_W = $clog2(BINS);

	logic [1:0]       scale_q;
	logic             valid_s1;
	logic [1:0]       cmd_s1;
	logic [15:0]      sample_s1;
	logic [8:0]       idx_s1;
	logic             tsel_s1;

	logic             keep;
	plh_kind_t        kind;
	logic [16:0]      coef;
	logic [31:0]      prod;
	logic [31:0]      scaled_w;
	logic [31:0]      idx_w;
	logic [ADDR_W-1:0] bin_addr;
	logic             s1_free;
	logic             accept;

	// The register port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_NONE;
		end else if (cfg_valid) begin
			scale_q <= scale_mode;
		end
	end

	// Decode the command; the unused code is dropped here.
	always_comb begin
		keep = 1'b1;
		kind = KIND_ADD;
		unique case (cmd_s1)
			CMD_ADD: begin
				kind = KIND_ADD;
			end
			CMD_CLEAR: begin
				kind = KIND_CLEAR;
			end
			CMD_READ: begin
				kind = KIND_READ;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// Scale the raw length by a Q16 factor; no scaling uses a factor of one.
	always_comb begin
		case (scale_q)
			SCALE_121:  coef = Q16_X1_21;
			SCALE_1452: coef = Q16_X1_452;
			default:    coef = Q16_ONE;
		endcase
	end

	assign prod     = {17'b0, sample_s1[LEN_W-1:0]} * {15'b0, coef};
	assign scaled_w = {16'b0, prod[31:16]};
	assign idx_w    = {23'b0, idx_s1};

	// Long lengths land in the last bin.
	always_comb begin
		if (scaled_w > 32'(BINS - 1)) begin
			bin_addr = ADDR_W'(BINS - 1);
		end else begin
			bin_addr = scaled_w[ADDR_W-1:0];
		end
	end

	// Build the queue request.
	always_comb begin
		push_hdr.kind      = kind;
		push_hdr.table_sel = (kind == KIND_ADD) ? sample_s1[PIT_BIT] : tsel_s1;
		push_hdr.oob       = (idx_w >= 32'(BINS));
		push_addr          = (kind == KIND_ADD) ? bin_addr : idx_w[ADDR_W-1:0];
	end

	assign push_valid = valid_s1 && keep && !q_full;
	assign s1_free    = !valid_s1 || !keep || !q_full;
	assign in_stall   = hold || !s1_free;
	assign accept     = in_valid && !in_stall;

	// Capture stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= command;
			sample_s1 <= sample;
			idx_s1    <= bin_index;
			tsel_s1   <= table_select;
		end
	end

endmodule

### design/plh_queue.sv
// Short request queue between the front and back ends.
module plh_queue import plh_pkg::*; #(
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  plh_hdr_t          push_hdr,
	input  logic [ADDR_W-1:0] push_addr,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output plh_hdr_t          head_hdr,
	output logic [ADDR_W-1:0] head_addr
);

	plh_hdr_t          hdr_q  [QUEUE_DEPTH];
	logic [ADDR_W-1:0] addr_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_hdr   = hdr_q[rd_ptr_q];
	assign head_addr  = addr_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push_valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push_valid) begin
			hdr_q[wr_ptr_q]  <= push_hdr;
			addr_q[wr_ptr_q] <= push_addr;
		end
	end

endmodule

### design/plh_back.sv
// Back end: table RAMs, read-modify-write with forwarding, clear sweep and result register.
module plh_back import plh_pkg::*; #(
	parameter int BINS = 512
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  plh_hdr_t                head_hdr,
	input  logic [$clog2(BINS)-1:0] head_addr,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [COUNT_W-1:0]      bin_count,
	output logic                    init_busy
);

	localparam int ADDR_W = $clog2(BINS);

	plh_back_state_t   state_q;
	plh_back_state_t   state_d;
	logic [ADDR_W-1:0] sweep_q;
	logic              sweep_en;
	logic              sweep_last;

	logic              s2_valid_q;
	plh_hdr_t          s2_hdr_q;
	logic [ADDR_W-1:0] s2_addr_q;

	logic              fwd_valid_q;
	logic              fwd_table_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [COUNT_W-1:0] fwd_data_q;

	logic              out_valid_q;
	logic [COUNT_W-1:0] out_data_q;

	logic              out_free;
	logic              s2_done;
	logic              s2_adv;
	logic              head_clear;
	logic              rd_en;
	logic              add_we;
	logic [COUNT_W-1:0] pit_rdata;
	logic [COUNT_W-1:0] land_rdata;
	logic [COUNT_W-1:0] old_count;
	logic [COUNT_W-1:0] new_count;
	logic [ADDR_W-1:0] wr_addr;
	logic [COUNT_W-1:0] wr_data;
	logic              pit_we;
	logic              land_we;

	assign sweep_last = (sweep_q == ADDR_W'(BINS - 1));

	// Sequencer outputs.
	always_comb begin
		sweep_en  = (state_q != BK_RUN);
		init_busy = (state_q == BK_INIT);
	end

	// Issue and completion control.
	assign out_free   = !out_valid_q || !out_stall;
	assign s2_done    = s2_valid_q && ((s2_hdr_q.kind != KIND_READ) || out_free);
	assign s2_adv     = !s2_valid_q || s2_done;
	assign head_clear = (head_hdr.kind == KIND_CLEAR);
	assign pop        = (state_q == BK_RUN) && head_valid &&
	                    (head_clear ? !s2_valid_q : s2_adv);
	assign rd_en      = pop && !head_clear;

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_INIT: begin
				if (sweep_last) state_d = BK_RUN;
			end
			BK_RUN: begin
				if (pop && head_clear) state_d = BK_CLEAR;
			end
			BK_CLEAR: begin
				if (sweep_last) state_d = BK_RUN;
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_INIT;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			if (sweep_en) begin
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
			end
		end
	end

	// Current bin value, taking the write of the previous cycle into account.
	always_comb begin
		if (fwd_valid_q && (fwd_table_q == s2_hdr_q.table_sel) && (fwd_addr_q == s2_addr_q)) begin
			old_count = fwd_data_q;
		end else begin
			old_count = s2_hdr_q.table_sel ? pit_rdata : land_rdata;
		end
	end

	// Saturating increment.
	assign new_count = (old_count == COUNT_MAX) ? old_count : old_count + 32'd1;
	assign add_we    = s2_valid_q && (s2_hdr_q.kind == KIND_ADD);

	// Write port shared by the sweep and the increment.
	assign wr_addr = sweep_en ? sweep_q : s2_addr_q;
	assign wr_data = sweep_en ? '0 : new_count;
	assign pit_we  = sweep_en || (add_we && s2_hdr_q.table_sel);
	assign land_we = sweep_en || (add_we && !s2_hdr_q.table_sel);

	plh_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (BINS)
	) u_pit_ram (
		.clk     (clk),
		.wr_en   (pit_we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (head_addr),
		.rd_data (pit_rdata)
	);

	plh_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (BINS)
	) u_land_ram (
		.clk     (clk),
		.wr_en   (land_we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (head_addr),
		.rd_data (land_rdata)
	);

	// Second stage control, forwarding valid and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q  <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_adv) begin
				s2_valid_q <= rd_en;
			end
			if (sweep_en) begin
				fwd_valid_q <= 1'b0;
			end else if (add_we) begin
				fwd_valid_q <= 1'b1;
			end
			if (s2_valid_q && (s2_hdr_q.kind == KIND_READ) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			s2_hdr_q  <= head_hdr;
			s2_addr_q <= head_addr;
		end
		if (add_we) begin
			fwd_table_q <= s2_hdr_q.table_sel;
			fwd_addr_q  <= s2_addr_q;
			fwd_data_q  <= new_count;
		end
		if (s2_valid_q && (s2_hdr_q.kind == KIND_READ) && out_free) begin
			out_data_q <= s2_hdr_q.oob ? '0 : old_count;
		end
	end

	assign out_valid = out_valid_q;
	assign bin_count = out_data_q;

endmodule
